[sv/hsss_pkg.sv]
// Shared types, register codes and the half-step coil decode for the stepper sequencer.
package hsss_pkg;

	localparam int SPEED_W = 16;
	localparam int IV_W    = 16;
	localparam int PHASE_W = 3;
	localparam int COILS_W = 4;
	localparam int ADDR_W  = 3;
	localparam int DATA_W  = 32;

	localparam logic [IV_W-1:0]    MIN_IV_RESET = 16'd1000;
	localparam logic [IV_W-1:0]    MAX_IV_RESET = 16'd10000;
	localparam logic [COILS_W-1:0] COILS_RESET  = 4'b0001;

	// Unity in Q1.15
	localparam logic [SPEED_W-1:0] Q15_ONE = 16'h8000;

	// Register index, taken from the word address bit of paddr
	typedef enum logic {
		REG_MIN_IV = 1'b0,
		REG_MAX_IV = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [IV_W-1:0] min_iv;
		logic [IV_W-1:0] max_iv;
	} cfg_t;

	// One word leaving the interval pipeline
	typedef struct packed {
		logic            zero;
		logic            neg;
		logic [IV_W-1:0] iv;
	} iv_word_t;

	// Phase offsets per coil: bit i is high when (p + offset) mod 8 <= 2
	localparam logic [PHASE_W-1:0] COIL_OFFS [COILS_W] = '{3'd1, 3'd7, 3'd5, 3'd3};

	function automatic logic [COILS_W-1:0] coil_decode(input logic [PHASE_W-1:0] p);
		logic [COILS_W-1:0] bits;
		logic [PHASE_W-1:0] pos;
		bits = '0;
		for (int i = 0; i < COILS_W; i++) begin
			pos = p + COIL_OFFS[i];
			bits[i] = (pos <= 3'd2);
		end
		return bits;
	endfunction

endpackage

[sv/half_step_stepper_speed_sequencer_top.sv]
// Top level of the half-step stepper speed sequencer.
// Each accepted word on the input channel is one timer tick with a signed Q1.15 speed; each
// tick gives exactly one result word (coils, phase, stepped). One tick is accepted every
// clock cycle while the receiver takes results. A tick passes through the input register,
// the 16x16 interval product, the interval add and clamp, then the state register that
// holds the tick counter, phase and coils and doubles as the output register. That last
// stage closes the only loop between ticks, so the rate is one tick per cycle while results
// are taken. Empty stages keep taking ticks while a result waits. Registers: minimum step
// interval at address 0, maximum at address 4; change them only while the block is idle.
module half_step_stepper_speed_sequencer_top
	import hsss_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [ADDR_W-1:0]         paddr,
	input  logic [DATA_W-1:0]         pwdata,
	output logic [DATA_W-1:0]         prdata,
	output logic                      pready,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [SPEED_W-1:0] speed_cmd,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [COILS_W-1:0]        coils,
	output logic [PHASE_W-1:0]        phase,
	output logic                      stepped
);

	cfg_t     cfg;
	iv_word_t iv_word;
	logic     iv_valid;
	logic     iv_ready;

	hsss_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	hsss_interval u_interval (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.speed_cmd (speed_cmd),
		.dn_valid  (iv_valid),
		.dn_ready  (iv_ready),
		.dn_word   (iv_word)
	);

	hsss_phase u_phase (
		.clk       (clk),
		.arst_n    (arst_n),
		.up_valid  (iv_valid),
		.up_ready  (iv_ready),
		.up_word   (iv_word),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.coils     (coils),
		.phase     (phase),
		.stepped   (stepped)
	);

endmodule

[sv/hsss_cfg.sv]
// APB register file holding the minimum and maximum step intervals.
module hsss_cfg
	import hsss_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t     cfg_q;
	cfg_reg_t sel;
	logic     wr_en;

	assign sel    = cfg_reg_t'(paddr[2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// Write the addressed register on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_iv <= MIN_IV_RESET;
			cfg_q.max_iv <= MAX_IV_RESET;
		end else if (wr_en) begin
			unique case (sel)
				REG_MIN_IV: cfg_q.min_iv <= pwdata[IV_W-1:0];
				REG_MAX_IV: cfg_q.max_iv <= pwdata[IV_W-1:0];
				default:    ;
			endcase
		end
	end

	// Return the addressed register
	always_comb begin
		unique case (sel)
			REG_MIN_IV: prdata = {{(DATA_W-IV_W){1'b0}}, cfg_q.min_iv};
			REG_MAX_IV: prdata = {{(DATA_W-IV_W){1'b0}}, cfg_q.max_iv};
			default:    prdata = '0;
		endcase
	end

endmodule

[sv/hsss_interval.sv]
// Three-stage pipeline turning a speed command into a step interval.
module hsss_interval
	import hsss_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  cfg_t                      cfg,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [SPEED_W-1:0] speed_cmd,
	output logic                      dn_valid,
	input  logic                      dn_ready,
	output iv_word_t                  dn_word
);

	logic                      v_s1, v_s2, v_s3;
	logic                      rdy1, rdy2, rdy3;
	logic        [SPEED_W-1:0] speed_s1;
	logic        [2*IV_W-1:0]  prod_s2;
	logic                      zero_s2, neg_s2;
	iv_word_t                  word_s3;

	logic        [SPEED_W-1:0] comp;
	logic        [IV_W-1:0]    span;
	logic        [IV_W+1:0]    sum;
	logic        [IV_W-1:0]    iv;
	logic                      neg1;

	// A stage takes a word when it is empty or its word moves on
	assign rdy3     = !v_s3 || dn_ready;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;
	assign dn_valid = v_s3;
	assign dn_word  = word_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
		end
	end

	// Distance from full speed: 1.0 - |speed| in Q1.15
	assign neg1 = speed_s1[SPEED_W-1];
	assign comp = neg1 ? {1'b0, speed_s1[SPEED_W-2:0]} : (Q15_ONE - speed_s1);
	assign span = cfg.max_iv - cfg.min_iv;

	// Scale back into the configured range and clamp
	always_comb begin
		sum = {2'b00, cfg.min_iv} + {1'b0, prod_s2[2*IV_W-1:IV_W-1]};
		if (cfg.max_iv < cfg.min_iv) begin
			iv = cfg.max_iv;
		end else if (sum > {2'b00, cfg.max_iv}) begin
			iv = cfg.max_iv;
		end else if (sum < {2'b00, cfg.min_iv}) begin
			iv = cfg.min_iv;
		end else begin
			iv = sum[IV_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) speed_s1 <= speed_cmd;
		if (rdy2 && v_s1) begin
			prod_s2 <= comp * span;
			zero_s2 <= (speed_s1 == '0);
			neg_s2  <= neg1;
		end
		if (rdy3 && v_s2) begin
			word_s3.zero <= zero_s2;
			word_s3.neg  <= neg_s2;
			word_s3.iv   <= iv;
		end
	end

endmodule

[sv/hsss_phase.sv]
// Tick counter, half-step phase and coil drive; these registers are also the result word.
module hsss_phase
	import hsss_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               up_valid,
	output logic               up_ready,
	input  iv_word_t           up_word,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [COILS_W-1:0] coils,
	output logic [PHASE_W-1:0] phase,
	output logic               stepped
);

	logic [IV_W-1:0]    tick_q;
	logic [PHASE_W-1:0] phase_q;
	logic [COILS_W-1:0] coils_q;
	logic               stepped_q;
	logic               out_valid_q;
	logic               fire;
	logic [IV_W-1:0]    tick_inc;
	logic [PHASE_W-1:0] phase_nx;

	assign up_ready  = !out_valid_q || out_ready;
	assign fire      = up_valid && up_ready;
	assign out_valid = out_valid_q;
	assign coils     = coils_q;
	assign phase     = phase_q;
	assign stepped   = stepped_q;

	// Saturating tick count and the neighbouring phase
	assign tick_inc = (tick_q == '1) ? tick_q : tick_q + 1'b1;
	assign phase_nx = up_word.neg ? phase_q - 1'b1 : phase_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q      <= '0;
			phase_q     <= '0;
			coils_q     <= COILS_RESET;
			stepped_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (fire) begin
				if (up_word.zero) begin
					// Stop: drop the coils, park the phase, keep counting
					tick_q    <= tick_inc;
					phase_q   <= '0;
					coils_q   <= '0;
					stepped_q <= 1'b0;
				end else if (tick_inc >= up_word.iv) begin
					// Step: advance or retreat and decode the coils
					tick_q    <= '0;
					phase_q   <= phase_nx;
					coils_q   <= coil_decode(phase_nx);
					stepped_q <= 1'b1;
				end else begin
					tick_q    <= tick_inc;
					stepped_q <= 1'b0;
				end
			end
		end
	end

	a_step_moves_one: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !up_word.zero |=> !stepped_q || phase_q == $past(phase_q) + 3'd1
			|| phase_q == $past(phase_q) - 3'd1)
		else $error("phase moved by more than one half step");

	a_step_decodes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && stepped_q |-> coils_q == coil_decode(phase_q) && tick_q == '0)
		else $error("step left coils undecoded or counter uncleared");

	a_stop_parks: assert property (@(posedge clk) disable iff (!arst_n)
		fire && up_word.zero |=> coils_q == '0 && phase_q == '0 && !stepped_q)
		else $error("stop did not drop coils and park phase");

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the half-step stepper speed sequencer.
module tb_top
	import hsss_pkg::*;
;

	localparam int unsigned CYCLE_LIMIT = 50000;
	localparam int unsigned RAND_TICKS  = 90;
	localparam int unsigned HOLD_CYCLES = 250;

	typedef enum logic {
		ROW_TICK,
		ROW_WRITE
	} row_kind_t;

	typedef struct packed {
		logic [COILS_W-1:0] coils;
		logic [PHASE_W-1:0] phase;
		logic               stepped;
	} drive_t;

	typedef struct packed {
		row_kind_t           kind;
		cfg_reg_t            rsel;
		logic [SPEED_W-1:0]  val;
		logic                typed;
		drive_t              want;
	} script_row_t;

	localparam drive_t NO_WANT = '0;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      psel = 1'b0;
	logic                      penable = 1'b0;
	logic                      pwrite = 1'b0;
	logic [ADDR_W-1:0]         paddr = '0;
	logic [DATA_W-1:0]         pwdata = '0;
	logic [DATA_W-1:0]         prdata;
	logic                      pready;
	logic                      in_valid = 1'b0;
	logic                      in_ready;
	logic signed [SPEED_W-1:0] speed_cmd = '0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	logic [COILS_W-1:0]        coils;
	logic [PHASE_W-1:0]        phase;
	logic                      stepped;

	half_step_stepper_speed_sequencer_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.speed_cmd (speed_cmd),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.coils     (coils),
		.phase     (phase),
		.stepped   (stepped)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Mirror of the block's registers and stepping state
	logic [IV_W-1:0]    cfg_min = MIN_IV_RESET;
	logic [IV_W-1:0]    cfg_max = MAX_IV_RESET;
	logic [IV_W-1:0]    tick_cnt = '0;
	logic [PHASE_W-1:0] cur_phase = '0;
	logic [COILS_W-1:0] cur_coils = COILS_RESET;

	drive_t      drive_q [$];
	int unsigned fails = 0;
	int unsigned cycles = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned hold_reqs = 0;
	int unsigned hold_seen = 0;
	int unsigned hold_left = 0;
	logic [SPEED_W-1:0] run_speed = '0;
	int unsigned        run_left = 0;

	// Directed ticks and register writes; typed words are plain to read off
	script_row_t script [32] = '{
		'{ROW_TICK,  REG_MIN_IV, 16'h0001, 1'b1, '{4'b0001, 3'd0, 1'b0}},
		'{ROW_TICK,  REG_MIN_IV, 16'h0000, 1'b1, '{4'b0000, 3'd0, 1'b0}},
		'{ROW_WRITE, REG_MIN_IV, 16'd0,    1'b0, NO_WANT},
		'{ROW_WRITE, REG_MAX_IV, 16'd0,    1'b0, NO_WANT},
		'{ROW_TICK,  REG_MIN_IV, 16'h7FFF, 1'b1, '{4'b0011, 3'd1, 1'b1}},
		'{ROW_TICK,  REG_MIN_IV, 16'h8000, 1'b1, '{4'b0001, 3'd0, 1'b1}},
		'{ROW_TICK,  REG_MIN_IV, 16'hFFFF, 1'b1, '{4'b1001, 3'd7, 1'b1}},
		'{ROW_TICK,  REG_MIN_IV, 16'h0001, 1'b1, '{4'b0001, 3'd0, 1'b1}},
		'{ROW_TICK,  REG_MIN_IV, 16'h7FFF, 1'b1, '{4'b0011, 3'd1, 1'b1}},
		'{ROW_TICK,  REG_MIN_IV, 16'h0000, 1'b1, '{4'b0000, 3'd0, 1'b0}},
		'{ROW_TICK,  REG_MIN_IV, 16'h0000, 1'b1, '{4'b0000, 3'd0, 1'b0}},
		'{ROW_WRITE, REG_MIN_IV, 16'd5,    1'b0, NO_WANT},
		'{ROW_WRITE, REG_MAX_IV, 16'd5,    1'b0, NO_WANT},
		'{ROW_TICK,  REG_MIN_IV, 16'h0064, 1'b1, '{4'b0000, 3'd0, 1'b0}},
		'{ROW_TICK,  REG_MIN_IV, 16'hFF9C, 1'b1, '{4'b0000, 3'd0, 1'b0}},
		'{ROW_TICK,  REG_MIN_IV, 16'hFF9C, 1'b1, '{4'b1001, 3'd7, 1'b1}},
		'{ROW_WRITE, REG_MIN_IV, 16'd9,    1'b0, NO_WANT},
		'{ROW_WRITE, REG_MAX_IV, 16'd3,    1'b0, NO_WANT},
		'{ROW_TICK,  REG_MIN_IV, 16'h4000, 1'b0, NO_WANT},
		'{ROW_TICK,  REG_MIN_IV, 16'h4000, 1'b0, NO_WANT},
		'{ROW_TICK,  REG_MIN_IV, 16'h4000, 1'b0, NO_WANT},
		'{ROW_WRITE, REG_MIN_IV, 16'd0,    1'b0, NO_WANT},
		'{ROW_WRITE, REG_MAX_IV, 16'hFFFF, 1'b0, NO_WANT},
		'{ROW_TICK,  REG_MIN_IV, 16'h8001, 1'b0, NO_WANT},
		'{ROW_TICK,  REG_MIN_IV, 16'h8000, 1'b0, NO_WANT},
		'{ROW_TICK,  REG_MIN_IV, 16'h0001, 1'b0, NO_WANT},
		'{ROW_TICK,  REG_MIN_IV, 16'h7FFF, 1'b0, NO_WANT},
		'{ROW_WRITE, REG_MIN_IV, 16'hFFFF, 1'b0, NO_WANT},
		'{ROW_WRITE, REG_MAX_IV, 16'd0,    1'b0, NO_WANT},
		'{ROW_TICK,  REG_MIN_IV, 16'h0001, 1'b0, NO_WANT},
		'{ROW_TICK,  REG_MIN_IV, 16'h5555, 1'b0, NO_WANT},
		'{ROW_TICK,  REG_MIN_IV, 16'hAAAA, 1'b0, NO_WANT}
	};

	// Settings for the random phases, extremes among them
	logic [IV_W-1:0] rand_min [6] = '{16'd0,  16'd7, 16'd2, 16'd0,    16'hFFFF, 16'd1};
	logic [IV_W-1:0] rand_max [6] = '{16'd12, 16'd3, 16'd2, 16'hFFFF, 16'd0,    16'd30};

	function automatic void note_mismatch(input string what, input int unsigned want,
			input int unsigned got);
		fails++;
		if (fails <= 10)
			$display("mismatch on %s: expected %0d, got %0d", what, want, got);
	endfunction

	// Half-step coil pattern for each phase
	function automatic logic [COILS_W-1:0] coil_lookup(input logic [PHASE_W-1:0] p);
		case (p)
			3'd0:    return 4'b0001;
			3'd1:    return 4'b0011;
			3'd2:    return 4'b0010;
			3'd3:    return 4'b0110;
			3'd4:    return 4'b0100;
			3'd5:    return 4'b1100;
			3'd6:    return 4'b1000;
			default: return 4'b1001;
		endcase
	endfunction

	// Step interval for a speed magnitude of 0..32768
	function automatic logic [IV_W-1:0] interval_for(input logic [16:0] mag);
		logic [31:0] span;
		logic [31:0] iv;
		if (cfg_max < cfg_min)
			return cfg_max;
		span = (32'd32768 - 32'(mag)) * (32'(cfg_max) - 32'(cfg_min));
		iv = 32'(cfg_min) + (span >> 15);
		if (iv < 32'(cfg_min))
			iv = 32'(cfg_min);
		if (iv > 32'(cfg_max))
			iv = 32'(cfg_max);
		return iv[IV_W-1:0];
	endfunction

	// Advance the mirrored state by one tick and return the drive word it gives
	function automatic drive_t advance_drive(input logic [SPEED_W-1:0] s);
		logic [16:0] mag;
		drive_t      d;
		d.stepped = 1'b0;
		if (tick_cnt != 16'hFFFF)
			tick_cnt = tick_cnt + 16'd1;
		if (s == '0) begin
			cur_coils = '0;
			cur_phase = '0;
		end else begin
			mag = s[SPEED_W-1] ? (17'h10000 - {1'b0, s}) : {1'b0, s};
			if (tick_cnt >= interval_for(mag)) begin
				cur_phase = s[SPEED_W-1] ? cur_phase - 3'd1 : cur_phase + 3'd1;
				tick_cnt  = '0;
				cur_coils = coil_lookup(cur_phase);
				d.stepped = 1'b1;
			end
		end
		d.coils = cur_coils;
		d.phase = cur_phase;
		return d;
	endfunction

	// Runs of one speed with random content, broken up by noise
	function automatic logic [SPEED_W-1:0] pick_speed();
		if (run_left == 0) begin
			run_left = $urandom_range(1, 40);
			case ($urandom_range(9))
				0:       run_speed = '0;
				1:       run_speed = 16'h7FFF;
				2:       run_speed = 16'h8000;
				3:       run_speed = 16'h0001;
				4:       run_speed = -16'($urandom_range(1, 255));
				default: run_speed = 16'($urandom);
			endcase
		end
		run_left--;
		if ($urandom_range(99) < 15)
			return ($urandom_range(3) == 0) ? 16'h0000 : 16'($urandom);
		return run_speed;
	endfunction

	// Offer one tick, wait for it to be taken and queue its drive word
	task automatic send_tick(input logic [SPEED_W-1:0] s, input logic typed, input drive_t want);
		drive_t d;
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid  <= 1'b1;
		speed_cmd <= s;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		d = advance_drive(s);
		drive_q.push_back(typed ? want : d);
	endtask

	// Drop valid and hold until every queued word has come out
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (drive_q.size() != 0)
			@(posedge clk);
	endtask

	// Write a register, then read it back
	task automatic reg_write(input cfg_reg_t r, input logic [IV_W-1:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {r, 2'b00};
		pwdata  <= {16'h0000, v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (r == REG_MIN_IV)
			cfg_min = v;
		else
			cfg_max = v;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata[IV_W-1:0] !== v)
			note_mismatch("register readback", 32'(v), 32'(prdata[IV_W-1:0]));
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Receiver: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_reqs != hold_seen) begin
			hold_seen = hold_reqs;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Compare each word taken from the block with the oldest expectation
	always @(posedge clk) begin
		drive_t want;
		if (arst_n && out_valid && out_ready) begin
			if (drive_q.size() == 0) begin
				note_mismatch("word with nothing expected", 0, 32'({coils, phase, stepped}));
			end else begin
				want = drive_q.pop_front();
				if (coils !== want.coils)
					note_mismatch("coils", 32'(want.coils), 32'(coils));
				if (phase !== want.phase)
					note_mismatch("phase", 32'(want.phase), 32'(phase));
				if (stepped !== want.stepped)
					note_mismatch("stepped", 32'(want.stepped), 32'(stepped));
			end
		end
	end

	// Abandon a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part
		send_idle_pct = 12;
		recv_idle_pct = 74;
		foreach (script[i]) begin
			if (script[i].kind == ROW_WRITE) begin
				wait_drained();
				reg_write(script[i].rsel, script[i].val);
			end else begin
				send_tick(script[i].val, script[i].typed, script[i].want);
			end
		end

		// Random part: two settings per idling mode
		for (int p = 0; p < 6; p++) begin
			wait_drained();
			reg_write(REG_MIN_IV, rand_min[p]);
			reg_write(REG_MAX_IV, rand_max[p]);
			send_idle_pct = (p < 2) ? 12 : (p < 4) ? 74 : 0;
			recv_idle_pct = (p < 2) ? 74 : (p < 4) ? 12 : 0;
			for (int n = 0; n < RAND_TICKS; n++) begin
				if (p == 5 && n == 20)
					hold_reqs++;
				send_tick(pick_speed(), 1'b0, NO_WANT);
			end
		end

		wait_drained();
		repeat (10) @(posedge clk);
		if (fails == 0 && drive_q.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

[half_step_stepper_speed_sequencer_top.f]
sv/hsss_pkg.sv
sv/hsss_cfg.sv
sv/hsss_interval.sv
sv/hsss_phase.sv
sv/half_step_stepper_speed_sequencer_top.sv
verif/tb_top.sv
